// ===== rtl/core/vba_pkg.sv =====
package vba_pkg;

   localparam int FIELD_WIDTH = 32;
   localparam int COORD_WIDTH_DEFAULT = 32;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

// ===== rtl/core/vba_channels.sv =====
interface vba_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [vba_pkg::FIELD_WIDTH-1:0] x_coord;
   logic signed [vba_pkg::FIELD_WIDTH-1:0] y_coord;
   logic signed [vba_pkg::FIELD_WIDTH-1:0] z_coord;
   logic                                last_vertex;

   modport source (output valid, output x_coord, output y_coord, output z_coord,
                   output last_vertex, input ready);
   modport sink (input valid, input x_coord, input y_coord, input z_coord,
                 input last_vertex, output ready);
endinterface

interface vba_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [vba_pkg::FIELD_WIDTH-1:0] radius;
   logic [vba_pkg::FIELD_WIDTH-1:0] half_x;
   logic [vba_pkg::FIELD_WIDTH-1:0] half_y;
   logic [vba_pkg::FIELD_WIDTH-1:0] half_z;

   modport source (output valid, output radius, output half_x, output half_y,
                   output half_z, input ready);
   modport sink (input valid, input radius, input half_x, input half_y,
                 input half_z, output ready);
endinterface

// ===== rtl/core/vertex_bounds_accumulator.sv =====
// Each vertex beat forms its sum of squares bit-serially, one multiplier bit of
// all three axes per cycle; the next vertex is taken only after that.
// A last-vertex beat then takes the square root, which settles one result bit
// per cycle, before the result beat is offered.
// A new vertex is taken while a result beat waits in the output register.
// Synchronous active-high reset clears all bounds and drops the result valid.
module vertex_bounds_accumulator #(
   parameter int COORD_WIDTH = vba_pkg::COORD_WIDTH_DEFAULT
) (
   input logic  clock,
   input logic  reset,
   vba_req_if.sink   req_bus,
   vba_rsp_if.source rsp_bus
);

   localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
   localparam int FIELD_WIDTH = vba_pkg::FIELD_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SQRT,
      ST_HOLD
   } state_type;

   state_type               state_ff, state_in;
   logic                    last_ff, last_in;
   logic [COORD_WIDTH-1:0]  max_abs_x_ff, max_abs_x_in;
   logic [COORD_WIDTH-1:0]  max_abs_y_ff, max_abs_y_in;
   logic [COORD_WIDTH-1:0]  max_abs_z_ff, max_abs_z_in;
   logic [SQ_WIDTH-1:0]     max_sq_ff, max_sq_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FIELD_WIDTH-1:0]  radius_ff, radius_in;
   logic [FIELD_WIDTH-1:0]  half_x_ff, half_x_in;
   logic [FIELD_WIDTH-1:0]  half_y_ff, half_y_in;
   logic [FIELD_WIDTH-1:0]  half_z_ff, half_z_in;

   logic                     accept;
   logic                     rsp_free;
   logic [COORD_WIDTH-1:0]   mag_x, mag_y, mag_z;
   logic [SQ_WIDTH-1:0]      sum_sq;
   logic [SQ_WIDTH-1:0]      sq_max;
   logic [COORD_WIDTH-1:0]   root;
   logic                     rt_start;
   vba_pkg::unit_status_type sq_stat;
   vba_pkg::unit_status_type rt_stat;

   function automatic logic [COORD_WIDTH-1:0] coord_mag(input logic [COORD_WIDTH-1:0] raw);
      return raw[COORD_WIDTH-1] ? (~raw + 1'b1) : raw;
   endfunction

   assign accept   = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign mag_x    = coord_mag(req_bus.x_coord[COORD_WIDTH-1:0]);
   assign mag_y    = coord_mag(req_bus.y_coord[COORD_WIDTH-1:0]);
   assign mag_z    = coord_mag(req_bus.z_coord[COORD_WIDTH-1:0]);
   assign sq_max   = (sum_sq > max_sq_ff) ? sum_sq : max_sq_ff;
   assign rt_start = (state_ff == ST_SQUARE) && sq_stat.done && last_ff;

   vba_square_unit #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_square (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .mag_x  (mag_x),
      .mag_y  (mag_y),
      .mag_z  (mag_z),
      .sum_sq (sum_sq),
      .status (sq_stat)
   );

   vba_sqrt_unit #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (rt_start),
      .operand (sq_max),
      .root    (root),
      .status  (rt_stat)
   );

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      max_abs_x_in = max_abs_x_ff;
      max_abs_y_in = max_abs_y_ff;
      max_abs_z_in = max_abs_z_ff;
      max_sq_in    = max_sq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      radius_in    = radius_ff;
      half_x_in    = half_x_ff;
      half_y_in    = half_y_ff;
      half_z_in    = half_z_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_bus.last_vertex;
               if (mag_x > max_abs_x_ff) max_abs_x_in = mag_x;
               if (mag_y > max_abs_y_ff) max_abs_y_in = mag_y;
               if (mag_z > max_abs_z_ff) max_abs_z_in = mag_z;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (sq_stat.done) begin
               max_sq_in = sq_max;
               state_in  = last_ff ? ST_SQRT : ST_IDLE;
            end
         end
         ST_SQRT: begin
            if (rt_stat.done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               radius_in    = FIELD_WIDTH'(root);
               half_x_in    = FIELD_WIDTH'(max_abs_x_ff);
               half_y_in    = FIELD_WIDTH'(max_abs_y_ff);
               half_z_in    = FIELD_WIDTH'(max_abs_z_ff);
               max_abs_x_in = '0;
               max_abs_y_in = '0;
               max_abs_z_in = '0;
               max_sq_in    = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      last_ff   <= last_in;
      radius_ff <= radius_in;
      half_x_ff <= half_x_in;
      half_y_ff <= half_y_in;
      half_z_ff <= half_z_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_abs_x_ff <= '0;
         max_abs_y_ff <= '0;
         max_abs_z_ff <= '0;
         max_sq_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_abs_x_ff <= max_abs_x_in;
         max_abs_y_ff <= max_abs_y_in;
         max_abs_z_ff <= max_abs_z_in;
         max_sq_ff    <= max_sq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_bus.ready  = (state_ff == ST_IDLE);
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.radius = radius_ff;
   assign rsp_bus.half_x = half_x_ff;
   assign rsp_bus.half_y = half_y_ff;
   assign rsp_bus.half_z = half_z_ff;

   a_accept_unit_free: assert property (@(posedge clock) disable iff (reset)
      accept |-> !sq_stat.busy && !rt_stat.busy)
      else $error("vertex taken while an arithmetic unit is busy");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(sq_stat.busy && rt_stat.busy))
      else $error("square and root units active together");

   a_result_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_HOLD))
      else $error("result beat raised outside the hold state");

   a_cleared_after_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (max_sq_ff == '0) && (max_abs_x_ff == '0))
      else $error("bounds not cleared after result");

endmodule

// ===== rtl/core/vba_square_unit.sv =====
module vba_square_unit #(
   parameter int COORD_WIDTH = vba_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [COORD_WIDTH-1:0]      mag_x,
   input  logic [COORD_WIDTH-1:0]      mag_y,
   input  logic [COORD_WIDTH-1:0]      mag_z,
   output logic [2*COORD_WIDTH-1:0]    sum_sq,
   output vba_pkg::unit_status_type    status
);

   localparam int SQ_WIDTH  = 2 * COORD_WIDTH;
   localparam int CNT_WIDTH = $clog2(COORD_WIDTH);

   logic [COORD_WIDTH-1:0] mx_ff, my_ff, mz_ff;
   logic [COORD_WIDTH-1:0] mx_in, my_in, mz_in;
   logic [COORD_WIDTH-1:0] sx_ff, sy_ff, sz_ff;
   logic [COORD_WIDTH-1:0] sx_in, sy_in, sz_in;
   logic [SQ_WIDTH-1:0]    acc_ff, acc_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [COORD_WIDTH+1:0] part;

   // Multiplier bits leave the shift registers MSB first, one per cycle for all
   // three axes, so the accumulator doubles and adds the selected multiplicands.
   assign part = (sx_ff[COORD_WIDTH-1] ? (COORD_WIDTH+2)'(mx_ff) : '0)
               + (sy_ff[COORD_WIDTH-1] ? (COORD_WIDTH+2)'(my_ff) : '0)
               + (sz_ff[COORD_WIDTH-1] ? (COORD_WIDTH+2)'(mz_ff) : '0);

   always_comb begin
      mx_in   = mx_ff;
      my_in   = my_ff;
      mz_in   = mz_ff;
      sx_in   = sx_ff;
      sy_in   = sy_ff;
      sz_in   = sz_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         mx_in   = mag_x;
         my_in   = mag_y;
         mz_in   = mag_z;
         sx_in   = mag_x;
         sy_in   = mag_y;
         sz_in   = mag_z;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[SQ_WIDTH-2:0], 1'b0} + SQ_WIDTH'(part);
         sx_in  = {sx_ff[COORD_WIDTH-2:0], 1'b0};
         sy_in  = {sy_ff[COORD_WIDTH-2:0], 1'b0};
         sz_in  = {sz_ff[COORD_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_WIDTH'(COORD_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mx_ff  <= mx_in;
      my_ff  <= my_in;
      mz_ff  <= mz_in;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
      sz_ff  <= sz_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sum_sq      = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== rtl/core/vba_sqrt_unit.sv =====
module vba_sqrt_unit #(
   parameter int COORD_WIDTH = vba_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [2*COORD_WIDTH-1:0]    operand,
   output logic [COORD_WIDTH-1:0]      root,
   output vba_pkg::unit_status_type    status
);

   localparam int SQ_WIDTH  = 2 * COORD_WIDTH;
   localparam int REM_WIDTH = COORD_WIDTH + 2;
   localparam int CNT_WIDTH = $clog2(COORD_WIDTH);

   logic [SQ_WIDTH-1:0]    n_ff, n_in;
   logic [REM_WIDTH-1:0]   rem_ff, rem_in;
   logic [COORD_WIDTH-1:0] root_ff, root_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [REM_WIDTH-1:0]   rem_shift;
   logic [REM_WIDTH-1:0]   trial;

   // Restoring square root: two operand bits enter the remainder per cycle and
   // one root bit is decided.
   assign rem_shift = {rem_ff[COORD_WIDTH-1:0], n_ff[SQ_WIDTH-1 -: 2]};
   assign trial     = {root_ff, 2'b01};

   always_comb begin
      n_in    = n_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = operand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in   = {n_ff[SQ_WIDTH-3:0], 2'b00};
         cnt_in = cnt_ff + 1'b1;
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[COORD_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[COORD_WIDTH-2:0], 1'b0};
         end
         if (cnt_ff == CNT_WIDTH'(COORD_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign root        = root_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== sim/vertex_bounds_accumulator_test.sv =====
module vertex_bounds_accumulator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = vba_pkg::FIELD_WIDTH;
   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 80;
   localparam int LONG_HOLD = 500;
   localparam logic signed [W-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [W-1:0] COORD_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic [W-1:0] radius;
      logic [W-1:0] half_x;
      logic [W-1:0] half_y;
      logic [W-1:0] half_z;
   } mesh_bounds_type;

   logic clock;
   logic reset;

   vba_req_if req_bus ();
   vba_rsp_if rsp_bus ();

   vertex_bounds_accumulator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Running bounds of the mesh in flight, as the block should hold them.
   logic [2*W-1:0] peak_sq_length;
   logic [W-1:0]   peak_abs_x;
   logic [W-1:0]   peak_abs_y;
   logic [W-1:0]   peak_abs_z;

   mesh_bounds_type expected_bounds[$];
   int              error_count;
   int              req_gap_max;
   int              rsp_gap_max;
   int              rsp_hold_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [W-1:0] magnitude(input logic [W-1:0] raw);
      return raw[W-1] ? (~raw + 1'b1) : raw;
   endfunction

   // Floor square root, found by setting result bits from the top down.
   function automatic logic [W-1:0] floor_root(input logic [2*W-1:0] n);
      logic [W-1:0]   root;
      logic [W-1:0]   trial;
      logic [2*W-1:0] trial_sq;
      root = '0;
      for (int i = W - 1; i >= 0; i--) begin
         trial = root | (W'(1) << i);
         trial_sq = {{W{1'b0}}, trial} * {{W{1'b0}}, trial};
         if (trial_sq <= n) begin
            root = trial;
         end
      end
      return root;
   endfunction

   task automatic accumulate_vertex(input logic [W-1:0] x, input logic [W-1:0] y,
                                    input logic [W-1:0] z, input logic last);
      logic [W-1:0]    ax;
      logic [W-1:0]    ay;
      logic [W-1:0]    az;
      logic [2*W-1:0]  sq;
      mesh_bounds_type bounds;
      ax = magnitude(x);
      ay = magnitude(y);
      az = magnitude(z);
      sq = {{W{1'b0}}, ax} * {{W{1'b0}}, ax} + {{W{1'b0}}, ay} * {{W{1'b0}}, ay}
         + {{W{1'b0}}, az} * {{W{1'b0}}, az};
      if (sq > peak_sq_length) peak_sq_length = sq;
      if (ax > peak_abs_x) peak_abs_x = ax;
      if (ay > peak_abs_y) peak_abs_y = ay;
      if (az > peak_abs_z) peak_abs_z = az;
      if (last) begin
         bounds.radius = floor_root(peak_sq_length);
         bounds.half_x = peak_abs_x;
         bounds.half_y = peak_abs_y;
         bounds.half_z = peak_abs_z;
         expected_bounds.push_back(bounds);
         peak_sq_length = '0;
         peak_abs_x = '0;
         peak_abs_y = '0;
         peak_abs_z = '0;
      end
   endtask

   // Valid stays high after a beat so that a following beat with no gap
   // needs only one assignment in its time step.
   task automatic send_vertex(input logic signed [W-1:0] x, input logic signed [W-1:0] y,
                              input logic signed [W-1:0] z, input logic last);
      int gap;
      gap = $urandom_range(req_gap_max, 0);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.x_coord <= x;
      req_bus.y_coord <= y;
      req_bus.z_coord <= z;
      req_bus.last_vertex <= last;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      accumulate_vertex(x, y, z, last);
   endtask

   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_bounds.size() != 0);
   endtask

   function automatic logic signed [W-1:0] random_coord();
      logic [W-1:0] v;
      case ($urandom_range(7, 0))
         0, 1, 2: return $urandom;
         3: return W'($urandom_range(32'h3FFFF, 0)) - 32'h20000;
         4: begin
            case ($urandom_range(4, 0))
               0: return COORD_MIN;
               1: return COORD_MAX;
               2: return '0;
               3: return -1;
               default: return 1;
            endcase
         end
         5: begin
            v = W'(1) << $urandom_range(W - 1, 0);
            return $urandom_range(1, 0) ? -v : v;
         end
         default: return W'($urandom_range(32'h01FF_FFFF, 0)) - 32'h0100_0000;
      endcase
   endfunction

   task automatic send_random_meshes(input int vertex_total);
      int sent;
      int mesh_len;
      sent = 0;
      while (sent < vertex_total) begin
         mesh_len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13)
                                                : $urandom_range(8, 1);
         for (int i = 0; i < mesh_len; i++) begin
            send_vertex(random_coord(), random_coord(), random_coord(), i == mesh_len - 1);
         end
         sent += mesh_len;
      end
   endtask

   task automatic test_extreme_vertices();
      send_vertex('0, '0, '0, 1'b1);
      send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
      send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
      send_vertex(COORD_MIN, '0, COORD_MAX, 1'b1);
      send_vertex(-1, 1, -32'sh10000, 1'b1);
   endtask

   task automatic test_mesh_accumulation();
      send_vertex(32'sh10000, -32'sh20000, 32'sh30000, 1'b0);
      send_vertex(-32'sh50000, 32'sh1000, -32'sh8000, 1'b0);
      send_vertex(32'sh100, 32'sh7FFF0000, -32'sh100, 1'b0);
      send_vertex(1, -1, 1, 1'b1);
      send_vertex(5, 5, 5, 1'b0);
      send_vertex(-32'sh7FFFFFFF, 3, COORD_MIN, 1'b1);
   endtask

   // A small mesh right after a large one shows that the bounds were cleared.
   task automatic test_bounds_cleared();
      send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
      send_vertex(7, 7, 7, 1'b1);
      send_vertex(2, -3, 4, 1'b1);
   endtask

   task automatic test_random_meshes(input int vertex_total);
      req_gap_max = 18;
      rsp_gap_max = 18;
      send_random_meshes(vertex_total);
   endtask

   task automatic test_back_to_back(input int vertex_total);
      req_gap_max = 0;
      rsp_gap_max = 0;
      send_random_meshes(vertex_total);
      wait_results_drained();
   endtask

   // The receiver stalls long enough for a finished result to sit in the
   // output register while the next mesh completes behind it.
   task automatic test_output_backpressure();
      wait_results_drained();
      req_gap_max = 0;
      rsp_hold_cycles = LONG_HOLD;
      for (int m = 0; m < 5; m++) begin
         send_vertex(random_coord(), random_coord(), random_coord(), 1'b0);
         send_vertex(random_coord(), random_coord(), random_coord(), 1'b1);
      end
      wait_results_drained();
   endtask

   initial begin : result_checker
      int              stall;
      mesh_bounds_type want;
      mesh_bounds_type got;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = $urandom_range(rsp_gap_max, 0);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         got = {rsp_bus.radius, rsp_bus.half_x, rsp_bus.half_y, rsp_bus.half_z};
         if (expected_bounds.size() == 0) begin
            $display("%0t: result beat with no mesh pending, actual %h", $time, got);
            error_count++;
         end else begin
            want = expected_bounds.pop_front();
            if (got != want) begin
               $display("%0t: bounds mismatch radius expected %h actual %h", $time,
                        want.radius, got.radius);
               $display("%0t: half_x expected %h actual %h, half_y expected %h actual %h",
                        $time, want.half_x, got.half_x, want.half_y, got.half_y);
               $display("%0t: half_z expected %h actual %h", $time, want.half_z, got.half_z);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.x_coord <= '0;
      req_bus.y_coord <= '0;
      req_bus.z_coord <= '0;
      req_bus.last_vertex <= 1'b0;
      error_count = 0;
      req_gap_max = 18;
      rsp_gap_max = 18;
      rsp_hold_cycles = 0;
      peak_sq_length = '0;
      peak_abs_x = '0;
      peak_abs_y = '0;
      peak_abs_z = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_extreme_vertices();
      test_mesh_accumulation();
      test_bounds_cleared();
      test_random_meshes(300);
      test_back_to_back(200);
      test_output_backpressure();
      test_random_meshes(420);

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
